// File: sv/rde_pkg.sv
`timescale 1ns / 1ps

package rde_pkg;

  localparam int NUM_W         = 31;
  localparam int DEN_W         = 6;
  localparam int DIG_W         = 4;
  localparam int VAL_W         = 31;
  localparam int PROD_W        = DEN_W + 4;
  localparam int STEP_W        = $clog2(NUM_W + 1);
  localparam int DIGIT_STEPS   = 4;
  localparam int RUN_DIGIT_CAP = 60;
  localparam int S_TDATA_W     = 40;
  localparam int M_TDATA_W     = 32;
  localparam int M_TUSER_W     = 3;
  localparam logic [DIG_W-1:0] BASE = DIG_W'(10);

  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_DIGIT = 2'd1,
    KIND_OPEN  = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_IDIV,
    S_IOUT,
    S_ZERO,
    S_DDIV,
    S_INS,
    S_CMP,
    S_CHK,
    S_ALIGN,
    S_EMIT,
    S_CLOSE
  } state_e;

  // One stored step of the long division: the remainder that produced the
  // digit, the digit itself and a mark for the first digit of the cycle.
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DIG_W-1:0] digit;
    logic             cyc;
  } entry_t;

endpackage

// File: sv/rde_div.sv
`timescale 1ns / 1ps

module rde_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rde_pkg::DEN_W-1:0]  rem_init_i,
  input  logic [rde_pkg::NUM_W-1:0]  dvd_i,
  input  logic [rde_pkg::STEP_W-1:0] steps_i,
  input  logic [rde_pkg::DEN_W-1:0]  den_i,
  output logic                      busy_o,
  output logic [rde_pkg::NUM_W-1:0]  quot_o,
  output logic [rde_pkg::DEN_W-1:0]  rem_o
);
  import rde_pkg::*;

  logic [STEP_W-1:0] cnt_q;
  logic [DEN_W-1:0]  den_q, rem_q;
  logic [NUM_W-1:0]  acc_q;
  logic [DEN_W:0]    trial, diff;
  logic              ge;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of acc_q while the quotient bits shift in at the bottom.
  assign trial = {rem_q, acc_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= steps_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= rem_init_i;
      acc_q <= dvd_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      acc_q <= {acc_q[NUM_W-2:0], ge};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = acc_q;
  assign rem_o  = rem_q;

endmodule

// File: sv/rde_cell.sv
`timescale 1ns / 1ps

module rde_cell (
  input  logic                     clk_i,
  input  logic                     shift_i,
  input  logic                     cmp_i,
  input  logic                     active_i,
  input  logic [rde_pkg::DEN_W-1:0] rem_i,
  input  rde_pkg::entry_t          prev_i,
  output rde_pkg::entry_t          entry_o
);
  import rde_pkg::*;

  entry_t entry_q;

  // Remainders held within one run are distinct, so at most one cell marks.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= prev_i;
    end else if (cmp_i) begin
      entry_q.cyc <= active_i && (entry_q.rem == rem_i);
    end
  end

  assign entry_o = entry_q;

endmodule

// File: sv/repeating_decimal_expander.sv
`timescale 1ns / 1ps
// Expands numerator/denominator into its decimal form, one fraction at a time.
// Each input transaction gives a run of output transactions: the integer
// quotient (tuser kind 0), then the fraction digits (kind 1), with the
// repeating part framed by an open (kind 2) and a close (kind 3) item; tlast
// marks the end of the run. A zero denominator gives one item with the error
// flag set, and an exact quotient gives the quotient followed by a single 0.
// The digit search stops after min(MAX_DIGITS, 60) digits without brackets.
// Sequence: the integer division runs in the bit-serial divider, each
// fraction digit then takes 4 divider steps plus the store, compare and check
// of the remainder row, and the row then shifts its oldest digit to the end
// before the n digits stream out; an output stall holds the stream. The next
// fraction is taken once the last item is queued.
module repeating_decimal_expander #(
  parameter int MAX_DIGITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [30:0] numerator, [36:31] denominator, [39:37] zero
  input  logic [rde_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [30:0] value, [31] zero
  output logic [rde_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] kind, [2] divide_error
  output logic [rde_pkg::M_TUSER_W-1:0] m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);
  import rde_pkg::*;

  localparam int Limit = (MAX_DIGITS < RUN_DIGIT_CAP) ? MAX_DIGITS : RUN_DIGIT_CAP;
  localparam int CntW  = $clog2(Limit + 1);

  state_e state_q, state_d;

  logic [NUM_W-1:0] s_num;
  logic [DEN_W-1:0] s_den;
  logic             s_hs, load_ok;

  logic [DEN_W-1:0] r_q, den_q;
  logic [CntW-1:0]  idx_q, pos_q, ecnt_q;
  logic             found_q, br_q;

  logic             m_valid_q;
  kind_e            m_kind_q;
  logic [VAL_W-1:0] m_value_q;
  logic             m_err_q, m_last_q;

  // FSM outputs
  logic             out_load, out_err, out_last;
  kind_e            out_kind;
  logic [VAL_W-1:0] out_value;
  logic             div_start, div_int, chain_shift, chain_cmp;

  logic               div_busy;
  logic [NUM_W-1:0]   div_quot;
  logic [DEN_W-1:0]   div_rem;
  logic [PROD_W-1:0]  prod;
  logic [DEN_W-1:0]   div_rem_init, div_den;
  logic [NUM_W-1:0]   div_dvd;
  logic [STEP_W-1:0]  div_steps;

  entry_t             chain_w [0:Limit];
  entry_t             tail;
  logic [Limit-1:0]   cyc_w;
  logic               cyc_any, run_done, open_now, emit_final;

  assign s_num   = s_axis_tdata_i[NUM_W-1:0];
  assign s_den   = s_axis_tdata_i[NUM_W+DEN_W-1:NUM_W];
  assign s_hs    = s_axis_tvalid_i && s_axis_tready_o;
  assign load_ok = !m_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == S_IDLE);

  // Divider shared by the integer quotient and every fraction digit.
  assign prod         = PROD_W'(r_q) * PROD_W'(BASE);
  assign div_rem_init = div_int ? '0 : prod[PROD_W-1:DIGIT_STEPS];
  assign div_dvd      = div_int ? s_num
                                : {prod[DIGIT_STEPS-1:0], (NUM_W - DIGIT_STEPS)'(0)};
  assign div_steps    = div_int ? STEP_W'(NUM_W) : STEP_W'(DIGIT_STEPS);
  assign div_den      = div_int ? s_den : den_q;

  rde_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem_init),
    .dvd_i      (div_dvd),
    .steps_i    (div_steps),
    .den_i      (div_den),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Row of cells: new entries enter at cell 0, the oldest one leaves at the end.
  assign chain_w[0] = '{rem: r_q, digit: div_quot[DIG_W-1:0], cyc: 1'b0};

  for (genvar gi = 0; gi < Limit; gi++) begin : g_cell
    rde_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (chain_shift),
      .cmp_i    (chain_cmp),
      .active_i (idx_q > CntW'(gi)),
      .rem_i    (r_q),
      .prev_i   (chain_w[gi]),
      .entry_o  (chain_w[gi+1])
    );
    assign cyc_w[gi] = chain_w[gi+1].cyc;
  end

  assign tail       = chain_w[Limit];
  assign cyc_any    = |cyc_w;
  assign run_done   = cyc_any || (r_q == '0) || (idx_q == CntW'(Limit));
  assign open_now   = tail.cyc && !br_q;
  assign emit_final = (ecnt_q == CntW'(idx_q - 1'b1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_hs) state_d = (s_den == '0) ? S_ERR : S_IDIV;
      S_ERR:   if (load_ok) state_d = S_IDLE;
      S_IDIV:  if (!div_busy) state_d = S_IOUT;
      S_IOUT:  if (load_ok) state_d = (r_q == '0) ? S_ZERO : S_DDIV;
      S_ZERO:  if (load_ok) state_d = S_IDLE;
      S_DDIV:  if (!div_busy) state_d = S_INS;
      S_INS:   state_d = S_CMP;
      S_CMP:   state_d = S_CHK;
      S_CHK:   state_d = run_done ? S_ALIGN : S_DDIV;
      S_ALIGN: if (pos_q == CntW'(Limit)) state_d = S_EMIT;
      S_EMIT: begin
        if (load_ok && !open_now && emit_final) begin
          state_d = found_q ? S_CLOSE : S_IDLE;
        end
      end
      S_CLOSE: if (load_ok) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_load    = 1'b0;
    out_kind    = KIND_INT;
    out_value   = '0;
    out_err     = 1'b0;
    out_last    = 1'b0;
    div_start   = 1'b0;
    div_int     = 1'b0;
    chain_shift = 1'b0;
    chain_cmp   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        div_int   = 1'b1;
        div_start = s_hs && (s_den != '0);
      end
      S_ERR: begin
        out_load = load_ok;
        out_err  = 1'b1;
        out_last = 1'b1;
      end
      S_IOUT: begin
        out_load  = load_ok;
        out_value = div_quot;
        div_start = load_ok && (r_q != '0);
      end
      S_ZERO: begin
        out_load = load_ok;
        out_kind = KIND_DIGIT;
        out_last = 1'b1;
      end
      S_INS:   chain_shift = 1'b1;
      S_CMP:   chain_cmp   = 1'b1;
      S_CHK:   div_start   = !run_done;
      S_ALIGN: chain_shift = (pos_q != CntW'(Limit));
      S_EMIT: begin
        out_load = load_ok;
        if (open_now) begin
          out_kind = KIND_OPEN;
        end else begin
          out_kind    = KIND_DIGIT;
          out_value   = VAL_W'(tail.digit);
          out_last    = !found_q && emit_final;
          chain_shift = load_ok;
        end
      end
      S_CLOSE: begin
        out_load = load_ok;
        out_kind = KIND_CLOSE;
        out_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      r_q       <= '0;
      idx_q     <= '0;
      pos_q     <= '0;
      ecnt_q    <= '0;
      found_q   <= 1'b0;
      br_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (s_hs && (s_den == '0)) begin
        r_q   <= '0;
        idx_q <= '0;
      end
      if ((state_q == S_IDIV || state_q == S_INS) && !div_busy) begin
        r_q <= div_rem;
      end
      if (state_q == S_IOUT) begin
        idx_q <= '0;
      end
      if (state_q == S_INS) begin
        idx_q <= idx_q + 1'b1;
      end
      if (state_q == S_CHK && run_done) begin
        pos_q   <= idx_q;
        ecnt_q  <= '0;
        found_q <= cyc_any;
        br_q    <= 1'b0;
      end
      if (state_q == S_ALIGN && chain_shift) begin
        pos_q <= pos_q + 1'b1;
      end
      if (state_q == S_EMIT && load_ok) begin
        if (open_now) begin
          br_q <= 1'b1;
        end else begin
          br_q   <= 1'b0;
          ecnt_q <= ecnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_kind_q  <= out_kind;
      m_value_q <= out_value;
      m_err_q   <= out_err;
      m_last_q  <= out_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      den_q <= s_den;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_value_q};
  assign m_axis_tuser_o  = {m_err_q, m_kind_q};
  assign m_axis_tlast_o  = m_last_q;

endmodule
